### src/mcbd_pkg.sv
// mcbd_pkg: shared types and constants of the mip chain box downsampler
// request structs for the pixel input and the result output, register indexes
// no dependencies
package mcbd_pkg;

  localparam int unsigned NUM_CHAN  = 4;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned SUM_W     = 10;
  localparam int unsigned LEVEL_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 13;
  localparam int unsigned BPP_W     = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP    = 2'd2;

  typedef struct packed {
    logic [7:0] chan0_in;
    logic [7:0] chan1_in;
    logic [7:0] chan2_in;
    logic [7:0] chan3_in;
  } in_pixel_t;

  typedef struct packed {
    logic [3:0] mip_level;
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
    logic [7:0] chan3_out;
    logic       last_of_run;
  } out_result_t;

endpackage

### src/mcbd_lane.sv
// mcbd_lane: one channel lane of the box filter
// forms the horizontal pair sum, the 2x2 average and the pair average
// depends on mcbd_pkg
module mcbd_lane (
  input  logic [mcbd_pkg::CHAN_W-1:0] pix_i,
  input  logic [mcbd_pkg::CHAN_W-1:0] pend_i,
  input  logic [mcbd_pkg::SUM_W-1:0]  row_sum_i,
  output logic [mcbd_pkg::SUM_W-1:0]  pair_sum_o,
  output logic [mcbd_pkg::CHAN_W-1:0] avg_quad_o,
  output logic [mcbd_pkg::CHAN_W-1:0] avg_pair_o
);
  import mcbd_pkg::*;

  logic [SUM_W:0] quad_sum;

  assign pair_sum_o = SUM_W'(pend_i) + SUM_W'(pix_i);
  assign quad_sum   = (SUM_W+1)'(row_sum_i) + (SUM_W+1)'(pair_sum_o);
  // truncating divides
  assign avg_quad_o = quad_sum[CHAN_W+1:2];
  assign avg_pair_o = pair_sum_o[CHAN_W:1];

endmodule

### src/mip_chain_box_downsampler.sv
// mip_chain_box_downsampler: streaming mip chain generator, top level
// level sequencer, row sum memory, output register; uses mcbd_pkg, mcbd_lane
//
// Base pixels come in raster order, one request each. Every pixel is sent out
// as level 0, then walked up the mip chain one level per cycle while the output
// register is free and no row sum read is pending: a level whose 2x2 block (or
// pair, once a dimension is 1) completes with this pixel emits its averaged
// pixel and hands it on to the next level. At each level where the bottom right
// pixel of a 2x2 block needs the stored even-row pair sum from the single port
// row sum memory, the step waits for that read. A new pixel is taken in the
// cycle its predecessor's last result goes to the output register. Mips are
// built only when width and height are both powers of two. A write to the
// width, height or bpp register restarts the frame.
module mip_chain_box_downsampler #(
  parameter int unsigned MAX_DIM      = 4096,
  parameter int unsigned MAX_LEVELS   = 13,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  mcbd_pkg::in_pixel_t                 in_pixel_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output mcbd_pkg::out_result_t               out_result_o,
  input  logic                                cfg_we_i,
  input  logic [mcbd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mcbd_pkg::CFG_W-1:0]          cfg_data_i
);
  import mcbd_pkg::*;

  localparam int unsigned PW  = $clog2(MAX_DIM);      // position / address bits
  localparam int unsigned DW  = PW + 1;               // dimension bits
  localparam int unsigned LIW = $clog2(MAX_LEVELS);   // level index bits
  localparam int unsigned RW  = NUM_CHAN * SUM_W;

  // configuration registers
  logic [CFG_W-1:0] width_q, height_q;
  logic [BPP_W-1:0] bpp_q;
  logic             cfg_hit;

  // sequencer state
  logic                busy_q, busy_d;
  logic                phase_q, phase_d;
  logic [LIW-1:0]      lvl_q, lvl_d;
  logic [CHAN_W-1:0]   pix_q [NUM_CHAN];
  logic [CHAN_W-1:0]   pix_d [NUM_CHAN];

  logic [PW-1:0]       col_q  [MAX_LEVELS];
  logic [PW-1:0]       row_q  [MAX_LEVELS];
  logic [CHAN_W-1:0]   pend_q [MAX_LEVELS][NUM_CHAN];

  logic [RW-1:0]       row_mem [MAX_DIM];
  logic [RW-1:0]       rd_q;

  logic                out_valid_q;
  out_result_t         out_q;

  // derived frame geometry
  function automatic logic [DW-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    if (v == '0) return DW'(1);
    if (32'(v) > MAX_DIM) return DW'(MAX_DIM);
    return DW'(v);
  endfunction

  function automatic logic [LEVEL_W:0] log2_of(input logic [DW-1:0] v);
    logic [LEVEL_W:0] p;
    p = '0;
    for (int i = 1; i < DW; i++) begin
      if (v[i]) p = (LEVEL_W+1)'(i);
    end
    return p;
  endfunction

  logic [DW-1:0]      w, h, ws, hs, w_sh, h_sh;
  logic [LEVEL_W:0]   lw, lh, lmax;
  logic [LEVEL_W+1:0] nlev;
  logic [BPP_W-1:0]   ch;

  always_comb begin
    w  = clamp_dim(width_q);
    h  = clamp_dim(height_q);
    lw = log2_of(w);
    lh = log2_of(h);
    lmax = (lw > lh) ? lw : lh;
    if (((w & (w - DW'(1))) == '0) && ((h & (h - DW'(1))) == '0)) begin
      nlev = (LEVEL_W+2)'(lmax) + (LEVEL_W+2)'(1);
      if (32'(nlev) > MAX_LEVELS) nlev = (LEVEL_W+2)'(MAX_LEVELS);
    end else begin
      nlev = (LEVEL_W+2)'(1);
    end
    ch = bpp_q;
    if (ch > BPP_W'(NUM_CHAN)) ch = BPP_W'(NUM_CHAN);
    if (32'(ch) > MAX_CHANNELS) ch = BPP_W'(MAX_CHANNELS);
    w_sh = w >> lvl_q;
    h_sh = h >> lvl_q;
    ws = (w_sh == '0) ? DW'(1) : w_sh;
    hs = (h_sh == '0) ? DW'(1) : h_sh;
  end

  // current level position and decisions
  logic [PW-1:0] c, r;
  logic          top_lvl, two_d, need_mem, slot_free, step_fire, emit, last, fin;
  logic [DW-1:0] idx_full;
  logic [PW-1:0] idx;

  always_comb begin
    c        = col_q[lvl_q];
    r        = row_q[lvl_q];
    top_lvl  = ((LEVEL_W+2)'(lvl_q) + (LEVEL_W+2)'(1)) >= nlev;
    two_d    = (ws > DW'(1)) && (hs > DW'(1));
    need_mem = !top_lvl && two_d && c[0] && r[0];
    idx_full = (w - w_sh) + DW'(c >> 1);
    idx      = (32'(idx_full) >= MAX_DIM) ? PW'(MAX_DIM - 1) : idx_full[PW-1:0];
    slot_free = !out_valid_q || out_ready_i;
    step_fire = busy_q && slot_free && !(need_mem && !phase_q);
    if (two_d) emit = c[0] && r[0];
    else       emit = (ws > DW'(1)) ? c[0] : r[0];
    last = top_lvl || !emit;
    fin  = step_fire && last;
  end

  assign in_ready_o = !busy_q || fin;

  // channel lanes
  logic [SUM_W-1:0]  pair_sum [NUM_CHAN];
  logic [CHAN_W-1:0] avg_quad [NUM_CHAN];
  logic [CHAN_W-1:0] avg_pair [NUM_CHAN];
  logic [RW-1:0]     wr_data;

  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_lane
    mcbd_lane u_lane (
      .pix_i      (pix_q[g]),
      .pend_i     (pend_q[lvl_q][g]),
      .row_sum_i  (rd_q[g*SUM_W +: SUM_W]),
      .pair_sum_o (pair_sum[g]),
      .avg_quad_o (avg_quad[g]),
      .avg_pair_o (avg_pair[g])
    );
    assign wr_data[g*SUM_W +: SUM_W] = pair_sum[g];
  end

  // row sum write: even row, odd column of a 2x2 level
  logic mem_we;
  assign mem_we = step_fire && !top_lvl && two_d && c[0] && !r[0];

  always_ff @(posedge clk_i) begin
    if (mem_we) row_mem[idx] <= wr_data;
    rd_q <= row_mem[idx];
  end

  // next pixel: merged lane results or a fresh input
  logic [CHAN_W-1:0] in_chan [NUM_CHAN];
  assign in_chan[0] = in_pixel_i.chan0_in;
  assign in_chan[1] = in_pixel_i.chan1_in;
  assign in_chan[2] = in_pixel_i.chan2_in;
  assign in_chan[3] = in_pixel_i.chan3_in;

  logic accept;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    lvl_d   = lvl_q;
    pix_d   = pix_q;
    if (busy_q && !step_fire && need_mem) phase_d = 1'b1;
    if (step_fire) begin
      phase_d = 1'b0;
      if (last) begin
        busy_d = 1'b0;
      end else begin
        lvl_d = lvl_q + LIW'(1);
        for (int i = 0; i < NUM_CHAN; i++) pix_d[i] = two_d ? avg_quad[i] : avg_pair[i];
      end
    end
    if (accept) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      lvl_d   = '0;
      for (int i = 0; i < NUM_CHAN; i++) pix_d[i] = (BPP_W'(i) < ch) ? in_chan[i] : '0;
    end
  end

  assign cfg_hit = cfg_we_i && ((cfg_index_i == CFG_WIDTH) || (cfg_index_i == CFG_HEIGHT) ||
                                (cfg_index_i == CFG_BPP));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= CFG_W'(1);
      height_q    <= CFG_W'(1);
      bpp_q       <= BPP_W'(4);
      busy_q      <= 1'b0;
      phase_q     <= 1'b0;
      lvl_q       <= '0;
      out_valid_q <= 1'b0;
      for (int l = 0; l < MAX_LEVELS; l++) begin
        col_q[l] <= '0;
        row_q[l] <= '0;
        for (int i = 0; i < NUM_CHAN; i++) pend_q[l][i] <= '0;
      end
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      lvl_q   <= lvl_d;
      if (step_fire)        out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (cfg_we_i && (cfg_index_i == CFG_WIDTH))  width_q  <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == CFG_HEIGHT)) height_q <= cfg_data_i;
      if (cfg_we_i && (cfg_index_i == CFG_BPP))    bpp_q    <= cfg_data_i[BPP_W-1:0];
      if (cfg_hit) begin
        // frame restart
        for (int l = 0; l < MAX_LEVELS; l++) begin
          col_q[l] <= '0;
          row_q[l] <= '0;
          for (int i = 0; i < NUM_CHAN; i++) pend_q[l][i] <= '0;
        end
      end else if (step_fire) begin
        // raster position advance with wrap at frame end
        if ((DW'(c) + DW'(1)) >= ws) begin
          col_q[lvl_q] <= '0;
          row_q[lvl_q] <= ((DW'(r) + DW'(1)) >= hs) ? '0 : r + PW'(1);
        end else begin
          col_q[lvl_q] <= c + PW'(1);
        end
        // hold the left or upper pixel of a pair
        if (!top_lvl && !(two_d ? c[0] : ((ws > DW'(1)) ? c[0] : r[0]))) begin
          for (int i = 0; i < NUM_CHAN; i++) pend_q[lvl_q][i] <= pix_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q.mip_level   <= LEVEL_W'(lvl_q);
      out_q.chan0_out   <= pix_q[0];
      out_q.chan1_out   <= pix_q[1];
      out_q.chan2_out   <= pix_q[2];
      out_q.chan3_out   <= pix_q[3];
      out_q.last_of_run <= last;
    end
    for (int i = 0; i < NUM_CHAN; i++) pix_q[i] <= pix_d[i];
  end

  assign out_valid_o  = out_valid_q;
  assign out_result_o = out_q;

endmodule
